@@ hdl/bsc_pkg.sv @@
// ----------------------------------------------------------------------------
// bsc_pkg
// shared types and constants for the b-spline curve point evaluator
// ----------------------------------------------------------------------------
package bsc_pkg;

	localparam int NUM_POINTS_DEF = 4;
	localparam int DEGREE_DEF     = 3;

	localparam logic [1:0] OP_EVAL  = 2'd0;
	localparam logic [1:0] OP_POINT = 2'd1;
	localparam logic [1:0] OP_KNOT  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_INDEX = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [2:0]         entry_index;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic [15:0]        knot_value;
		logic [15:0]        param_t;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] curve_x;
		logic signed [15:0] curve_y;
		logic               from_eval;
		logic [1:0]         status;
	} out_item_t;

	// divider control and status
	typedef struct packed {
		logic        start;
		logic [32:0] dividend;
		logic [16:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [32:0] quotient;
	} div_rsp_t;

endpackage

@@ hdl/bsc_div.sv @@
// ----------------------------------------------------------------------------
// bsc_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bsc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  bsc_pkg::div_req_t req,
	output bsc_pkg::div_rsp_t rsp
);

	logic [32:0] quo_q;
	logic [16:0] rem_q;
	logic [16:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [17:0] trial;

	assign trial = {rem_q, quo_q[32]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd33;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[17]) begin
				rem_q <= trial[16:0];
				quo_q <= {quo_q[31:0], 1'b1};
			end else begin
				rem_q <= {rem_q[15:0], quo_q[32]};
				quo_q <= {quo_q[31:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

@@ hdl/bspline_curve_point_eval.sv @@
// ----------------------------------------------------------------------------
// bspline_curve_point_eval
// b-spline curve point evaluation by the cox-de boor recursion
// ----------------------------------------------------------------------------
// channel  direction  payload     handshake
// in       input      in_item_t   in_valid / in_ready
// out      output     out_item_t  out_valid / out_ready
//
// a write answers the cycle after acceptance. an evaluate first builds the
// degree-zero basis, then works 2 x (K-1-p) terms for each degree p, K = knot
// count, each by a divide (issue, shift out the quotient bits, collect) or
// skipped when its numerator, denominator or basis value is not positive,
// then accumulates NUM_POINTS products and rounds. stores clear at reset. a
// waiting result holds off the next transaction until it is taken.
// ----------------------------------------------------------------------------
module bspline_curve_point_eval #(
	parameter int NUM_POINTS = bsc_pkg::NUM_POINTS_DEF,
	parameter int DEGREE     = bsc_pkg::DEGREE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bsc_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output bsc_pkg::out_item_t  out_data
);

	localparam int NK = NUM_POINTS + DEGREE + 1;
	localparam int KW = $clog2(NK);
	localparam int PW = $clog2(NUM_POINTS);
	localparam int DW = $clog2(DEGREE + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_BASE, S_TERM, S_WAIT, S_ACC, S_DONE, S_OUT
	} state_t;

	state_t      state_q;
	logic [15:0] cx_q [NUM_POINTS];
	logic [15:0] cy_q [NUM_POINTS];
	logic [15:0] knot_q [NK];
	logic [16:0] basis_q [NK];
	logic [15:0] t_q;
	logic [KW-1:0] i_q;
	logic [DW-1:0] p_q;
	logic        half_q;
	logic [31:0] term_q;
	logic signed [40:0] sx_q, sy_q;
	bsc_pkg::out_item_t res_q;

	bsc_pkg::div_req_t dreq;
	bsc_pkg::div_rsp_t drsp;

	bsc_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// operands of the current term
	logic [KW:0]        ia, ib, ic, id;
	logic signed [17:0] num, den;
	logic [16:0]        bsel;
	logic               skip;
	logic [31:0]        vsum;
	logic [16:0]        vclamp;
	logic               last_i;
	logic               last_p;
	logic signed [33:0] px, py;
	logic [PW-1:0]      ip;

	always_comb begin
		ia = {1'b0, i_q} + {1'b0, KW'(half_q)};
		ib = {1'b0, i_q} + (KW+1)'(p_q) + {{KW{1'b0}}, half_q};
		ic = ia;
		id = ib;
		if (!half_q) begin
			num = $signed({2'b0, t_q}) - $signed({2'b0, knot_q[ia[KW-1:0]]});
			den = $signed({2'b0, knot_q[ib[KW-1:0]]})
				- $signed({2'b0, knot_q[ic[KW-1:0]]});
		end else begin
			num = $signed({2'b0, knot_q[id[KW-1:0]]}) - $signed({2'b0, t_q});
			den = $signed({2'b0, knot_q[id[KW-1:0]]})
				- $signed({2'b0, knot_q[ia[KW-1:0]]});
		end
		bsel = basis_q[ia[KW-1:0]];
		skip = (num <= 0) || (den <= 0) || (bsel == 17'd0);
		dreq.start    = (state_q == S_TERM) && !skip;
		dreq.dividend = 33'(num[15:0]) * 33'(bsel);
		dreq.divisor  = den[16:0];
		// the pair of terms adds modulo 2^32 before the clamp
		vsum = term_q + (skip ? 32'd0 : drsp.quotient[31:0]);
		vclamp = (vsum > 32'h10000) ? 17'h10000 : vsum[16:0];
		last_i = (32'(i_q) + 32'(p_q) + 2 >= NK);
		last_p = (32'(p_q) == DEGREE);
		ip = i_q[PW-1:0];
		px = $signed(cx_q[ip]) * $signed({1'b0, basis_q[i_q]});
		py = $signed(cy_q[ip]) * $signed({1'b0, basis_q[i_q]});
	end

	function automatic logic [15:0] rsat(input logic signed [40:0] s);
		logic signed [40:0] b;
		logic signed [24:0] q;
		b = s + 41'sd32768;
		q = b[40:16];
		if (q > 25'sd32767) return 16'h7fff;
		if (q < -25'sd32768) return 16'h8000;
		return q[15:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int k = 0; k < NUM_POINTS; k++) begin
				cx_q[k] <= '0;
				cy_q[k] <= '0;
			end
			for (int k = 0; k < NK; k++) knot_q[k] <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					t_q <= in_data.param_t;
					case (in_data.opcode)
						bsc_pkg::OP_EVAL: begin
							if (in_data.param_t < knot_q[0]
								|| in_data.param_t >= knot_q[NK-1]) begin
								res_q <= '{16'sd0, 16'sd0, 1'b1, bsc_pkg::ST_RANGE};
								state_q <= S_OUT;
							end else
								state_q <= S_BASE;
						end
						bsc_pkg::OP_POINT: begin
							if (32'(in_data.entry_index) < NUM_POINTS) begin
								cx_q[PW'(in_data.entry_index)] <= in_data.point_x;
								cy_q[PW'(in_data.entry_index)] <= in_data.point_y;
								res_q <= '{16'sd0, 16'sd0, 1'b0, bsc_pkg::ST_OK};
							end else
								res_q <= '{16'sd0, 16'sd0, 1'b0, bsc_pkg::ST_INDEX};
							state_q <= S_OUT;
						end
						bsc_pkg::OP_KNOT: begin
							if (32'(in_data.entry_index) < NK) begin
								knot_q[KW'(in_data.entry_index)] <= in_data.knot_value;
								res_q <= '{16'sd0, 16'sd0, 1'b0, bsc_pkg::ST_OK};
							end else
								res_q <= '{16'sd0, 16'sd0, 1'b0, bsc_pkg::ST_INDEX};
							state_q <= S_OUT;
						end
						default: begin
							res_q <= '{16'sd0, 16'sd0, 1'b0, bsc_pkg::ST_INDEX};
							state_q <= S_OUT;
						end
					endcase
				end
				S_BASE: begin
					for (int k = 0; k < NK - 1; k++)
						basis_q[k] <= (t_q >= knot_q[k] && t_q < knot_q[k+1])
							? 17'h10000 : 17'd0;
					basis_q[NK-1] <= '0;
					i_q <= '0;
					p_q <= DW'(1);
					half_q <= 1'b0;
					term_q <= '0;
					state_q <= S_TERM;
				end
				S_TERM: begin
					if (skip) begin
						if (!half_q) half_q <= 1'b1;
						else begin
							basis_q[i_q] <= vclamp;
							half_q <= 1'b0;
							term_q <= '0;
							if (last_i) begin
								i_q <= '0;
								if (last_p) begin
									sx_q <= '0;
									sy_q <= '0;
									state_q <= S_ACC;
								end else p_q <= p_q + DW'(1);
							end else i_q <= i_q + KW'(1);
						end
					end else state_q <= S_WAIT;
				end
				S_WAIT: if (drsp.done) begin
					if (!half_q) begin
						term_q <= vsum;
						half_q <= 1'b1;
						state_q <= S_TERM;
					end else begin
						basis_q[i_q] <= vclamp;
						half_q <= 1'b0;
						term_q <= '0;
						if (last_i) begin
							i_q <= '0;
							if (last_p) begin
								sx_q <= '0;
								sy_q <= '0;
								state_q <= S_ACC;
							end else begin
								p_q <= p_q + DW'(1);
								state_q <= S_TERM;
							end
						end else begin
							i_q <= i_q + KW'(1);
							state_q <= S_TERM;
						end
					end
				end
				S_ACC: begin
					sx_q <= sx_q + 41'(px);
					sy_q <= sy_q + 41'(py);
					if (32'(i_q) == NUM_POINTS - 1) state_q <= S_DONE;
					else i_q <= i_q + KW'(1);
				end
				S_DONE: begin
					res_q <= '{rsat(sx_q), rsat(sy_q), 1'b1, bsc_pkg::ST_OK};
					state_q <= S_OUT;
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data  = res_q;

endmodule

@@ bench/bspline_curve_point_eval_tb.sv @@
// ----------------------------------------------------------------------------
// bspline_curve_point_eval_tb
// self-checking bench for the b-spline curve point evaluator: control point
// and knot writes, range and index errors, and curve evaluations are driven
// through the valid/ready input channel. a fixed-point cox-de boor model
// predicts every result, which is compared field by field on the output side
// ----------------------------------------------------------------------------
module bspline_curve_point_eval_tb;

	localparam int NPTS  = bsc_pkg::NUM_POINTS_DEF;
	localparam int DEG   = bsc_pkg::DEGREE_DEF;
	localparam int NKNOT = NPTS + DEG + 1;
	localparam longint ONE_Q16 = 65536;
	localparam logic [1:0] OP_BAD = 2'd3;
	localparam int STALL_LIMIT = 20000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	bsc_pkg::in_item_t  in_data;
	logic               out_valid;
	logic               out_ready;
	bsc_pkg::out_item_t out_data;

	logic signed [15:0] model_x [NPTS];
	logic signed [15:0] model_y [NPTS];
	logic [15:0]        model_knot [NKNOT];

	bsc_pkg::out_item_t curve_results_q [$];
	int        mismatches;
	int        idle_pct;
	int        quiet_cycles;

	bspline_curve_point_eval u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint weight_term(longint num, longint den, longint b);
		if (num <= 0 || den <= 0 || b == 0)
			return 0;
		return (num * b) / den;
	endfunction

	function automatic logic signed [15:0] round_clip(longint s);
		longint q;
		q = (s + 32768) >>> 16;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return q[15:0];
	endfunction

	// apply one transaction to the model state and return its result
	function automatic bsc_pkg::out_item_t predict_curve(bsc_pkg::in_item_t it);
		bsc_pkg::out_item_t r;
		longint    basis [NKNOT];
		longint    t, ui, uip, ui1, uip1, v, sx, sy;
		r = '0;
		t = it.param_t;
		case (it.opcode)
			bsc_pkg::OP_POINT: begin
				if (it.entry_index < NPTS) begin
					model_x[it.entry_index] = it.point_x;
					model_y[it.entry_index] = it.point_y;
				end else
					r.status = bsc_pkg::ST_INDEX;
			end
			bsc_pkg::OP_KNOT: begin
				if (it.entry_index < NKNOT)
					model_knot[it.entry_index] = it.knot_value;
				else
					r.status = bsc_pkg::ST_INDEX;
			end
			bsc_pkg::OP_EVAL: begin
				r.from_eval = 1'b1;
				if (t < model_knot[0] || t >= model_knot[NKNOT-1])
					r.status = bsc_pkg::ST_RANGE;
				else begin
					for (int i = 0; i < NKNOT - 1; i++)
						basis[i] = (t >= model_knot[i] && t < model_knot[i+1]) ? ONE_Q16 : 0;
					for (int p = 1; p <= DEG; p++) begin
						for (int i = 0; i < NKNOT - 1 - p; i++) begin
							ui   = model_knot[i];
							uip  = model_knot[i+p];
							ui1  = model_knot[i+1];
							uip1 = model_knot[i+p+1];
							// the two terms add modulo 2^32
							v = (weight_term(t - ui, uip - ui, basis[i])
							  + weight_term(uip1 - t, uip1 - ui1, basis[i+1]))
							  & 64'hFFFF_FFFF;
							basis[i] = v > ONE_Q16 ? ONE_Q16 : v;
						end
					end
					sx = 0;
					sy = 0;
					for (int i = 0; i < NPTS; i++) begin
						sx += longint'(model_x[i]) * basis[i];
						sy += longint'(model_y[i]) * basis[i];
					end
					r.curve_x = round_clip(sx);
					r.curve_y = round_clip(sy);
				end
			end
			default: r.status = bsc_pkg::ST_INDEX;
		endcase
		return r;
	endfunction

	task automatic send_item(bsc_pkg::in_item_t it);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_data  <= it;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		curve_results_q.push_back(predict_curve(it));
	endtask

	function automatic bsc_pkg::in_item_t make_item(logic [1:0] op, int idx, int px, int py,
			int knot, int t);
		bsc_pkg::in_item_t it;
		it.opcode      = op;
		it.entry_index = idx[2:0];
		it.point_x     = px[15:0];
		it.point_y     = py[15:0];
		it.knot_value  = knot[15:0];
		it.param_t     = t[15:0];
		return it;
	endfunction

	function automatic bsc_pkg::in_item_t noise_item(logic [1:0] op);
		return make_item(op, $urandom_range(7), $urandom, $urandom, $urandom, $urandom);
	endfunction

	task automatic load_knots(int first, int spread);
		int k;
		k = first;
		for (int i = 0; i < NKNOT; i++) begin
			send_item(make_item(bsc_pkg::OP_KNOT, i, $urandom, $urandom, k, $urandom));
			if ($urandom_range(3) != 0)
				k = k + $urandom_range(0, spread);
			if (k > 65535)
				k = 65535;
		end
	endtask

	task automatic test_directed();
		send_item(make_item(bsc_pkg::OP_EVAL, 0, 0, 0, 0, 0));
		send_item(make_item(bsc_pkg::OP_POINT, 0, 32767, -32768, 0, 0));
		send_item(make_item(bsc_pkg::OP_POINT, 3, -32768, 32767, 0, 0));
		send_item(make_item(bsc_pkg::OP_POINT, 4, 1, 1, 0, 0));
		send_item(make_item(bsc_pkg::OP_POINT, 7, -1, -1, 0, 0));
		send_item(make_item(OP_BAD, 5, -1, -1, 65535, 65535));
		send_item(make_item(bsc_pkg::OP_POINT, 1, 32767, 32767, 0, 0));
		send_item(make_item(bsc_pkg::OP_POINT, 2, -32768, -32768, 0, 0));
		// clamped knots 0 0 0 0 256 256 256 256
		for (int i = 0; i < NKNOT; i++)
			send_item(make_item(bsc_pkg::OP_KNOT, i, 0, 0, i < NKNOT / 2 ? 0 : 256, 0));
		send_item(make_item(bsc_pkg::OP_EVAL, 0, 0, 0, 0, 0));
		send_item(make_item(bsc_pkg::OP_EVAL, 0, 0, 0, 0, 128));
		send_item(make_item(bsc_pkg::OP_EVAL, 0, 0, 0, 0, 255));
		send_item(make_item(bsc_pkg::OP_EVAL, 0, 0, 0, 0, 256));
		// decreasing knot breaks the ordering
		send_item(make_item(bsc_pkg::OP_KNOT, 2, 0, 0, 65535, 0));
		send_item(make_item(bsc_pkg::OP_EVAL, 0, 0, 0, 0, 100));
		send_item(make_item(bsc_pkg::OP_KNOT, 7, 0, 0, 65535, 0));
		send_item(make_item(bsc_pkg::OP_EVAL, 0, 0, 0, 0, 65535));
	endtask

	task automatic test_random(int items);
		int n, t, lo, hi;
		n = 0;
		while (n < items) begin
			idle_pct = (n > items / 3 && n < items / 2) ? 0 : 6;
			case ($urandom_range(9))
				0: begin
					send_item(noise_item(2'($urandom_range(3))));
					n++;
				end
				1, 2: begin
					load_knots($urandom_range(0, 65535), $urandom_range(1, 16384));
					n += NKNOT;
				end
				3, 4: begin
					load_knots($urandom_range(0, 2048), $urandom_range(1, 2048));
					n += NKNOT;
				end
				5: begin
					send_item(make_item(bsc_pkg::OP_POINT, $urandom_range(7), $urandom,
						$urandom, $urandom, $urandom));
					n++;
				end
				default: begin
					lo = model_knot[0];
					hi = model_knot[NKNOT-1];
					if (hi > lo && $urandom_range(7) != 0)
						t = $urandom_range(lo, hi - 1);
					else
						t = $urandom;
					send_item(make_item(bsc_pkg::OP_EVAL, $urandom_range(7), $urandom,
						$urandom, $urandom, t));
					n++;
				end
			endcase
		end
		in_valid <= 1'b0;
		idle_pct = 6;
	endtask

	// output stall pattern
	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= (idle_pct == 0) || ($urandom_range(99) >= 6);
	end

	always @(posedge clk) begin
		bsc_pkg::out_item_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (curve_results_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: %p", out_data);
			end else begin
				exp_r = curve_results_q.pop_front();
				if (out_data.curve_x !== exp_r.curve_x || out_data.curve_y !== exp_r.curve_y
						|| out_data.from_eval !== exp_r.from_eval
						|| out_data.status !== exp_r.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", exp_r, out_data);
				end
			end
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		mismatches   = 0;
		quiet_cycles = 0;
		idle_pct     = 6;
		in_valid     = 1'b0;
		in_data      = '0;
		arst_n       = 1'b0;
		for (int i = 0; i < NPTS; i++) begin
			model_x[i] = '0;
			model_y[i] = '0;
		end
		for (int i = 0; i < NKNOT; i++)
			model_knot[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(830);
		while (curve_results_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/bsc_pkg.sv
hdl/bsc_div.sv
hdl/bspline_curve_point_eval.sv
bench/bspline_curve_point_eval_tb.sv
